// ===== src/cfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue package
// Shared types and codes for the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package cfq_pkg;

   localparam int WORD_W = 32;
   localparam int FUNC_W = 2;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DISPLAY = 2'd2;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = 1;
   localparam int CMDQ_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_REMOVE,
      OP_DISPLAY
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_OVERFLOW,
      ST_UNDERFLOW,
      ST_EMPTY
   } status_type;

   typedef struct packed {
      op_type op;
      logic signed [WORD_W-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_REMOVE,
      BK_DISPLAY
   } back_state_type;

endpackage

// ===== src/cfq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cfq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue front end
// Accepts request words, decodes the operation and holds them in a short
// command queue for the back end. Unused operation codes are dropped.
// ----------------------------------------------------------------------------
module cfq_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cfq_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [cfq_pkg::WORD_W-1:0] req_value,
   output logic                             cmd_valid,
   output cfq_pkg::cmd_type                 cmd,
   input  logic                             cmd_pop
);

   cfq_pkg::cmd_type entry_ff [cfq_pkg::CMDQ_DEPTH];
   logic [cfq_pkg::CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cfq_pkg::CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cfq_pkg::CMDQ_CNT_W-1:0] count_ff, count_in;
   logic is_cmd;
   cfq_pkg::op_type dec_op;
   logic push;

   always_comb begin
      is_cmd = 1'b1;
      dec_op = cfq_pkg::OP_INSERT;
      unique case (req_func)
         cfq_pkg::FUNC_INSERT: dec_op = cfq_pkg::OP_INSERT;
         cfq_pkg::FUNC_REMOVE: dec_op = cfq_pkg::OP_REMOVE;
         cfq_pkg::FUNC_DISPLAY: dec_op = cfq_pkg::OP_DISPLAY;
         default: is_cmd = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != cfq_pkg::CMDQ_CNT_W'(cfq_pkg::CMDQ_DEPTH));
   assign push = req_valid && req_ready && is_cmd;
   assign cmd_valid = (count_ff != '0);
   assign cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: dec_op, value: req_value};
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cfq_pkg::CMDQ_CNT_W'(cfq_pkg::CMDQ_DEPTH))
      else $error("command queue count exceeds its depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("command popped from an empty queue");
`endif

endmodule

// ===== src/cfq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue back end
// Keeps the front and rear indexes, stores and reads the words in the slot
// RAM and drives the registered response word stream.
// ----------------------------------------------------------------------------
module cfq_back #(
   parameter int DEPTH = 8,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  cfq_pkg::cmd_type                  cmd,
   output logic                              cmd_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cfq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [cfq_pkg::WORD_W-1:0] rsp_data,
   output logic                              rsp_last
);

   cfq_pkg::back_state_type state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic empty_ff, empty_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic out_valid_ff, out_valid_in;
   logic [cfq_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic signed [cfq_pkg::WORD_W-1:0] out_data_ff, out_data_in;
   logic out_last_ff, out_last_in;

   logic out_free;
   logic full;
   logic [IDX_W:0] dist_wide;
   logic ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [cfq_pkg::WORD_W-1:0] ram_rd_data;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   assign out_free = !out_valid_ff || rsp_ready;
   assign full = !empty_ff && (next_idx(tail_ff) == head_ff);
   assign dist_wide = (tail_ff >= head_ff)
      ? {1'b0, tail_ff} - {1'b0, head_ff}
      : {1'b0, tail_ff} + (IDX_W + 1)'(DEPTH) - {1'b0, head_ff};

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      empty_in = empty_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      cmd_pop = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = tail_ff;
      ram_rd_en = 1'b0;
      ram_rd_addr = head_ff;
      unique case (state_ff)
         cfq_pkg::BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  cfq_pkg::OP_INSERT: begin
                     out_valid_in = 1'b1;
                     out_data_in = '0;
                     out_last_in = 1'b1;
                     if (full) begin
                        out_status_in = cfq_pkg::ST_OVERFLOW;
                     end else begin
                        out_status_in = cfq_pkg::ST_OK;
                        ram_wr_en = 1'b1;
                        if (empty_ff) begin
                           head_in = '0;
                           tail_in = '0;
                           empty_in = 1'b0;
                        end else begin
                           tail_in = next_idx(tail_ff);
                        end
                        ram_wr_addr = tail_in;
                     end
                  end
                  cfq_pkg::OP_REMOVE: begin
                     if (empty_ff) begin
                        out_valid_in = 1'b1;
                        out_status_in = cfq_pkg::ST_UNDERFLOW;
                        out_data_in = '0;
                        out_last_in = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        ram_rd_addr = head_ff;
                        if (head_ff == tail_ff) begin
                           empty_in = 1'b1;
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           head_in = next_idx(head_ff);
                        end
                        state_in = cfq_pkg::BK_REMOVE;
                     end
                  end
                  cfq_pkg::OP_DISPLAY: begin
                     if (empty_ff) begin
                        out_valid_in = 1'b1;
                        out_status_in = cfq_pkg::ST_EMPTY;
                        out_data_in = '0;
                        out_last_in = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        ram_rd_addr = head_ff;
                        pos_in = head_ff;
                        cnt_in = dist_wide[IDX_W-1:0];
                        state_in = cfq_pkg::BK_DISPLAY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         cfq_pkg::BK_REMOVE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_status_in = cfq_pkg::ST_OK;
               out_data_in = ram_rd_data;
               out_last_in = 1'b1;
               state_in = cfq_pkg::BK_IDLE;
            end
         end
         cfq_pkg::BK_DISPLAY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_status_in = cfq_pkg::ST_OK;
               out_data_in = ram_rd_data;
               out_last_in = (cnt_ff == '0);
               if (cnt_ff == '0) begin
                  state_in = cfq_pkg::BK_IDLE;
               end else begin
                  pos_in = next_idx(pos_ff);
                  cnt_in = cnt_ff - 1'b1;
                  ram_rd_en = 1'b1;
                  ram_rd_addr = pos_in;
               end
            end
         end
         default: state_in = cfq_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfq_pkg::BK_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         empty_ff <= 1'b1;
         pos_ff <= '0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         empty_ff <= empty_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   cfq_ram #(
      .WIDTH(cfq_pkg::WORD_W),
      .DEPTH(DEPTH),
      .ADDR_W(IDX_W)
   ) u_slots (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(cmd.value),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_data = out_data_ff;
   assign rsp_last = out_last_ff;

`ifndef SYNTHESIS
   a_empty_indexes: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("queue is empty but an index is not zero");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff < IDX_W'(DEPTH)) && (tail_ff < IDX_W'(DEPTH)) || (IDX_W'(DEPTH) == '0))
      else $error("queue index beyond the last slot");
   a_display_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfq_pkg::BK_DISPLAY) |-> !empty_ff)
      else $error("display walk running on an empty queue");
`endif

endmodule

// ===== src/circular_fifo_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue
// Fixed-depth circular FIFO of signed words with insert, remove and display.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_func, req_value
// rsp      out        rsp_valid / rsp_ready  rsp_status, rsp_data, rsp_last
//
// An insert or any error is answered from the idle state, a remove via the remove state.
// A display sends the stored words front first, one slot RAM read a cycle unless stalled.
// A two-word command queue lets requests be taken while the back end works.
// A full response register stalls the back end; the command queue then fills up.
// Reset is synchronous and leaves the queue empty; slots need no clearing.
// ----------------------------------------------------------------------------
module circular_fifo_queue_top #(
   parameter int DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cfq_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [cfq_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cfq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [cfq_pkg::WORD_W-1:0] rsp_data,
   output logic                              rsp_last
);

   logic cmd_valid;
   logic cmd_pop;
   cfq_pkg::cmd_type cmd;

   cfq_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_value(req_value),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop)
   );

   cfq_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_data(rsp_data),
      .rsp_last(rsp_last)
   );

endmodule

// ===== tb/circular_fifo_queue_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue testbench
// Drives insert, remove, display and unused requests into the queue with random
// gaps on the request side and random stalls on the response side. An in-bench
// model of the queue predicts every response word, and the monitor checks each
// accepted word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module circular_fifo_queue_top_test;

   localparam int DEPTH = 8;
   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 9;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 38;
   localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [cfq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [cfq_pkg::FUNC_W-1:0] func;
      logic signed [cfq_pkg::WORD_W-1:0] value;
      int gap;
   } queue_req_type;

   typedef struct {
      cfq_pkg::status_type status;
      logic signed [cfq_pkg::WORD_W-1:0] data;
      logic last;
   } queue_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [cfq_pkg::FUNC_W-1:0] req_func = '0;
   logic signed [cfq_pkg::WORD_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [cfq_pkg::STATUS_W-1:0] rsp_status;
   logic signed [cfq_pkg::WORD_W-1:0] rsp_data;
   logic rsp_last;

   queue_req_type pending_reqs[$];
   queue_rsp_type expected_rsps[$];

   logic signed [cfq_pkg::WORD_W-1:0] model_slots [DEPTH];
   int model_head;
   int model_tail;
   logic model_empty;

   logic steady_phase = 1'b0;
   int req_wait = 0;
   int rsp_hold = 0;
   int idle_cycles = 0;
   int reqs_taken = 0;
   int rsps_taken = 0;
   int mismatches = 0;
   int overflows = 0;
   int underflows = 0;
   int empty_displays = 0;
   int displayed_words = 0;
   int ignored_reqs = 0;

   circular_fifo_queue_top #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_data(rsp_data),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int next_slot(input int idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
   endfunction

   function automatic void push_rsp(input cfq_pkg::status_type status,
                                    input logic signed [cfq_pkg::WORD_W-1:0] data,
                                    input logic last);
      queue_rsp_type rsp;
      rsp.status = status;
      rsp.data = data;
      rsp.last = last;
      expected_rsps.push_back(rsp);
   endfunction

   function automatic void predict_queue_op(input logic [cfq_pkg::FUNC_W-1:0] func,
                                            input logic signed [cfq_pkg::WORD_W-1:0] value);
      int count;
      int pos;
      case (func)
         cfq_pkg::FUNC_INSERT: begin
            if (!model_empty && next_slot(model_tail) == model_head) begin
               push_rsp(cfq_pkg::ST_OVERFLOW, '0, 1'b1);
               overflows++;
            end else begin
               if (model_empty) begin
                  model_head = 0;
                  model_tail = 0;
                  model_empty = 1'b0;
               end else begin
                  model_tail = next_slot(model_tail);
               end
               model_slots[model_tail] = value;
               push_rsp(cfq_pkg::ST_OK, '0, 1'b1);
            end
         end
         cfq_pkg::FUNC_REMOVE: begin
            if (model_empty) begin
               push_rsp(cfq_pkg::ST_UNDERFLOW, '0, 1'b1);
               underflows++;
            end else begin
               push_rsp(cfq_pkg::ST_OK, model_slots[model_head], 1'b1);
               if (model_head == model_tail) begin
                  model_empty = 1'b1;
                  model_head = 0;
                  model_tail = 0;
               end else begin
                  model_head = next_slot(model_head);
               end
            end
         end
         cfq_pkg::FUNC_DISPLAY: begin
            if (model_empty) begin
               push_rsp(cfq_pkg::ST_EMPTY, '0, 1'b1);
               empty_displays++;
            end else begin
               count = ((model_tail + DEPTH - model_head) % DEPTH) + 1;
               pos = model_head;
               for (int i = 0; i < count; i++) begin
                  push_rsp(cfq_pkg::ST_OK, model_slots[pos], (i == count - 1));
                  pos = next_slot(pos);
               end
               displayed_words += count;
            end
         end
         default: begin
            ignored_reqs++;
         end
      endcase
   endfunction

   function automatic logic signed [cfq_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_req(input logic [cfq_pkg::FUNC_W-1:0] func,
                          input logic signed [cfq_pkg::WORD_W-1:0] value);
      queue_req_type req;
      req.func = func;
      req.value = value;
      req.gap = steady_phase ? 0 : $urandom_range(0, 3);
      pending_reqs.push_back(req);
   endtask

   task automatic wait_reqs_drained();
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
   endtask

   // Request driver: presents the next pending word once its gap has elapsed.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_wait <= 0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() != 0 && req_wait >= pending_reqs[0].gap) begin
            req_valid <= 1'b1;
            req_func <= pending_reqs[0].func;
            req_value <= pending_reqs[0].value;
            pending_reqs.delete(0);
            req_wait <= 0;
         end else begin
            req_valid <= 1'b0;
            if (pending_reqs.size() != 0) begin
               req_wait <= req_wait + 1;
            end
         end
      end
   end

   // Monitor: predicts from accepted requests, checks accepted responses and
   // stalls the response side.
   always @(posedge clock) begin
      int stall;
      queue_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_queue_op(req_func, req_value);
            reqs_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            rsps_taken++;
            if (expected_rsps.size() == 0) begin
               $error("Unexpected response word: status %0d, data %0d, last %0d",
                      rsp_status, rsp_data, rsp_last);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_data !== want.data) begin
                  $error("rsp_data: expected %0d, got %0d", want.data, rsp_data);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last: expected %0d, got %0d", want.last, rsp_last);
                  mismatches++;
               end
            end
            stall = steady_phase ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               rsp_hold <= stall;
            end
         end else if (!rsp_ready) begin
            if (rsp_hold <= 1) begin
               rsp_ready <= 1'b1;
               rsp_hold <= 0;
            end else begin
               rsp_hold <= rsp_hold - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles with no handshake.", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int mode;
      int pick;
      logic [cfq_pkg::FUNC_W-1:0] func;
      model_head = 0;
      model_tail = 0;
      model_empty = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty queue, unused code, and a single entry inserted then removed.
      add_req(cfq_pkg::FUNC_DISPLAY, $urandom);
      add_req(cfq_pkg::FUNC_REMOVE, $urandom);
      add_req(FUNC_UNUSED, $urandom);
      add_req(cfq_pkg::FUNC_INSERT, $urandom);
      add_req(cfq_pkg::FUNC_REMOVE, $urandom);
      // Fill with extreme words, overflow, show, then wrap the rear around.
      add_req(cfq_pkg::FUNC_INSERT, 32'sh8000_0000);
      add_req(cfq_pkg::FUNC_INSERT, 32'sh7fff_ffff);
      add_req(cfq_pkg::FUNC_INSERT, '0);
      add_req(cfq_pkg::FUNC_INSERT, -32'sd1);
      add_req(cfq_pkg::FUNC_INSERT, 32'sh5555_5555);
      add_req(cfq_pkg::FUNC_INSERT, 32'shaaaa_aaaa);
      add_req(cfq_pkg::FUNC_INSERT, $urandom);
      add_req(cfq_pkg::FUNC_INSERT, $urandom);
      add_req(cfq_pkg::FUNC_INSERT, $urandom);
      add_req(cfq_pkg::FUNC_DISPLAY, $urandom);
      for (int i = 0; i < 3; i++) add_req(cfq_pkg::FUNC_REMOVE, $urandom);
      add_req(cfq_pkg::FUNC_INSERT, $urandom);
      add_req(cfq_pkg::FUNC_INSERT, $urandom);
      add_req(cfq_pkg::FUNC_DISPLAY, $urandom);
      wait_reqs_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         @(negedge clock);
         steady_phase = (phase % 4 == 2);
         mode = phase % 3;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            case (mode)
               0: func = (pick < 60) ? cfq_pkg::FUNC_INSERT :
                         (pick < 80) ? cfq_pkg::FUNC_REMOVE :
                         (pick < 96) ? cfq_pkg::FUNC_DISPLAY : FUNC_UNUSED;
               1: func = (pick < 25) ? cfq_pkg::FUNC_INSERT :
                         (pick < 78) ? cfq_pkg::FUNC_REMOVE :
                         (pick < 96) ? cfq_pkg::FUNC_DISPLAY : FUNC_UNUSED;
               default: func = (pick < 45) ? cfq_pkg::FUNC_INSERT :
                               (pick < 85) ? cfq_pkg::FUNC_REMOVE :
                               (pick < 97) ? cfq_pkg::FUNC_DISPLAY : FUNC_UNUSED;
            endcase
            add_req(func, pick_word());
         end
         wait_reqs_drained();
      end

      steady_phase = 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d ignored) and checked %0d response words.",
               reqs_taken, ignored_reqs, rsps_taken);
      $display("Saw %0d overflows, %0d underflows, %0d empty displays, %0d words shown.",
               overflows, underflows, empty_displays, displayed_words);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== circular_fifo_queue_top.f =====
src/cfq_pkg.sv
src/cfq_ram.sv
src/cfq_front.sv
src/cfq_back.sv
src/circular_fifo_queue_top.sv
tb/circular_fifo_queue_top_test.sv
